// File: rtl/core/sce_pkg.sv
// Shared types, codes and reset constants for the sensor calibration checker.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package sce_pkg;

	// Command codes of an input item
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_PIXEL  = 2'd1;
	localparam logic [1:0] CMD_MEAN   = 2'd2;
	localparam logic [1:0] CMD_STATUS = 2'd3;

	// Action codes of a result item
	localparam logic [2:0] ACT_GET_FRAME  = 3'd0;
	localparam logic [2:0] ACT_GET_MEAN   = 3'd1;
	localparam logic [2:0] ACT_GET_STATUS = 3'd2;
	localparam logic [2:0] ACT_DELAY_STAT = 3'd3;
	localparam logic [2:0] ACT_DONE       = 3'd4;
	localparam logic [2:0] ACT_NO_IMAGE   = 3'd5;
	localparam logic [2:0] ACT_NOT_CLEAR  = 3'd6;
	localparam logic [2:0] ACT_TIMEOUT    = 3'd7;

	// Status bytes reported by the sensor
	localparam logic [7:0] STATUS_BUSY  = 8'h01;
	localparam logic [7:0] STATUS_READY = 8'h03;

	// Configuration register indexes
	localparam logic [2:0] REG_PIXEL_COUNT  = 3'd0;
	localparam logic [2:0] REG_MAX_DELTA    = 3'd1;
	localparam logic [2:0] REG_MIN_MEAN     = 3'd2;
	localparam logic [2:0] REG_ROUND_BUDGET = 3'd3;
	localparam logic [2:0] REG_POLL_BUDGET  = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_PIXEL_COUNT  = 16'd6400;
	localparam logic [15:0] RST_MAX_DELTA    = 16'd500;
	localparam logic [15:0] RST_MIN_MEAN     = 16'd100;
	localparam logic [7:0]  RST_ROUND_BUDGET = 8'd5;
	localparam logic [7:0]  RST_POLL_BUDGET  = 8'd50;

	// Depth of the queue between front and back
	localparam int SCE_QUEUE_DEPTH = 4;

	// Classified item handed from front to back
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] data;
		logic        is_busy;
		logic        is_ready;
	} item_t;

	// Configuration register file contents
	typedef struct packed {
		logic [15:0] pixel_count;
		logic [15:0] max_delta;
		logic [15:0] min_mean;
		logic [7:0]  round_budget;
		logic [7:0]  poll_budget;
	} cfg_t;

	// Divider status seen by the back end
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sce_front.sv
// Front end: accepts input items and classifies them into item_t.
// Depends on sce_pkg.
`default_nettype none

module sce_front
	import sce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] data_value,
	output logic             push_valid,
	input  wire logic        push_ready,
	output item_t            push_item
);

	logic  valid_s1;
	item_t item_s1;

	// Take a new item whenever the stage is empty or draining this cycle
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd      <= command;
			item_s1.data     <= data_value;
			item_s1.is_busy  <= (data_value[7:0] == STATUS_BUSY);
			item_s1.is_ready <= (data_value[7:0] == STATUS_READY);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sce_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on sce_pkg for item_t.
`default_nettype none

module sce_queue
	import sce_pkg::*;
#(
	parameter int DEPTH = SCE_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic  [AW-1:0] wr_ptr_q;
	logic  [AW-1:0] rd_ptr_q;
	logic  [CW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sce_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sce_pkg for div_stat_t.
`default_nettype none

module sce_div
	import sce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        ack,
	input  wire logic [31:0] dividend,
	input  wire logic [16:0] divisor,
	output div_stat_t        stat,
	output logic [15:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [16:0] divisor_q;
	logic [16:0] trial;
	logic        fits;

	// Remainder stays below the divisor, so 16 bits hold it
	assign trial    = {rem_q, quo_q[31]};
	assign fits     = (trial >= divisor_q);
	assign stat     = '{busy: busy_q, done: done_q};
	assign quotient = quo_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (ack) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - divisor_q) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sce_back.sv
// Back end: calibration sequencer, frame accumulation and result register.
// Depends on sce_pkg and sce_div.
`default_nettype none

module sce_back
	import sce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire item_t       q_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       action,
	output logic [15:0]      frame_mean,
	output logic [15:0]      mean_delta
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_FRAME  = 3'd1;
	localparam logic [2:0] PH_MEAN   = 3'd2;
	localparam logic [2:0] PH_STATUS = 3'd3;
	localparam logic [2:0] PH_DIVIDE = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [31:0] sum_q, sum_d;
	logic [15:0] seen_q, seen_d;
	logic [7:0]  rounds_q, rounds_d;
	logic [7:0]  polls_q, polls_d;
	logic        busy_seen_q, busy_seen_d;
	logic [15:0] held_mean_q, held_mean_d;

	logic        out_valid_q;
	logic [2:0]  action_q;
	logic [15:0] frame_mean_q;
	logic [15:0] mean_delta_q;

	logic        out_free;
	logic        pop;
	logic        emit;
	logic [2:0]  emit_action;
	logic [15:0] emit_delta;

	logic        div_start;
	logic        div_ack;
	div_stat_t   div_stat;
	logic [15:0] div_quot;
	logic [16:0] divisor;

	logic [31:0] sum_next;
	logic [15:0] seen_next;
	logic [16:0] diff;
	logic [15:0] delta;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = q_valid && out_free && (phase_q != PH_DIVIDE);
	assign q_ready   = pop;

	assign sum_next  = sum_q + {16'd0, q_item.data};
	assign seen_next = seen_q + 1'b1;
	// A zero count means the counter wraps, so divide by 65536
	assign divisor   = (cfg.pixel_count == '0) ? 17'h10000 : {1'b0, cfg.pixel_count};

	assign diff  = {1'b0, held_mean_q} - {1'b0, q_item.data};
	assign delta = diff[16] ? (q_item.data - held_mean_q) : diff[15:0];

	always_comb begin
		phase_d     = phase_q;
		sum_d       = sum_q;
		seen_d      = seen_q;
		rounds_d    = rounds_q;
		polls_d     = polls_q;
		busy_seen_d = busy_seen_q;
		held_mean_d = held_mean_q;
		emit        = 1'b0;
		emit_action = ACT_GET_FRAME;
		emit_delta  = '0;
		div_start   = 1'b0;
		div_ack     = 1'b0;
		if (phase_q == PH_DIVIDE) begin
			if (div_stat.done && out_free) begin
				held_mean_d = div_quot;
				phase_d     = PH_MEAN;
				emit        = 1'b1;
				emit_action = ACT_GET_MEAN;
				div_ack     = 1'b1;
			end
		end else if (pop) begin
			unique case (q_item.cmd)
				CMD_START: begin
					if (phase_q == PH_IDLE) begin
						rounds_d    = cfg.round_budget;
						polls_d     = cfg.poll_budget;
						busy_seen_d = 1'b0;
						sum_d       = '0;
						seen_d      = '0;
						phase_d     = PH_FRAME;
						emit        = 1'b1;
						emit_action = ACT_GET_FRAME;
					end
				end
				CMD_PIXEL: begin
					if (phase_q == PH_FRAME) begin
						sum_d  = sum_next;
						seen_d = seen_next;
						if (seen_next == cfg.pixel_count) begin
							div_start = 1'b1;
							phase_d   = PH_DIVIDE;
						end
					end
				end
				CMD_MEAN: begin
					if (phase_q == PH_MEAN) begin
						emit       = 1'b1;
						emit_delta = delta;
						if (held_mean_q < cfg.min_mean) begin
							phase_d     = PH_IDLE;
							emit_action = ACT_NO_IMAGE;
						end else if (delta <= cfg.max_delta) begin
							phase_d     = PH_IDLE;
							emit_action = ACT_DONE;
						end else if (rounds_q == '0) begin
							phase_d     = PH_IDLE;
							emit_action = ACT_NOT_CLEAR;
						end else begin
							rounds_d    = rounds_q - 1'b1;
							polls_d     = cfg.poll_budget;
							busy_seen_d = 1'b0;
							phase_d     = PH_STATUS;
							emit_action = ACT_GET_STATUS;
						end
					end
				end
				CMD_STATUS: begin
					if (phase_q == PH_STATUS) begin
						emit = 1'b1;
						if (busy_seen_q && q_item.is_ready) begin
							sum_d       = '0;
							seen_d      = '0;
							phase_d     = PH_FRAME;
							emit_action = ACT_GET_FRAME;
						end else begin
							if (q_item.is_busy) begin
								busy_seen_d = 1'b1;
							end
							if (polls_q == '0) begin
								phase_d     = PH_IDLE;
								emit_action = ACT_TIMEOUT;
							end else begin
								polls_d     = polls_q - 1'b1;
								emit_action = ACT_DELAY_STAT;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sum_q       <= '0;
			seen_q      <= '0;
			rounds_q    <= RST_ROUND_BUDGET;
			polls_q     <= RST_POLL_BUDGET;
			busy_seen_q <= 1'b0;
			held_mean_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			sum_q       <= sum_d;
			seen_q      <= seen_d;
			rounds_q    <= rounds_d;
			polls_q     <= polls_d;
			busy_seen_q <= busy_seen_d;
			held_mean_q <= held_mean_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			action_q     <= emit_action;
			frame_mean_q <= held_mean_d;
			mean_delta_q <= emit_delta;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign frame_mean = frame_mean_q;
	assign mean_delta = mean_delta_q;

	sce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.ack      (div_ack),
		.dividend (sum_next),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Never restart the divider while it is still iterating
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// Hold the queue while a division is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIVIDE) |-> !pop)
		else $error("item popped during division");

	// Emit only into a free or draining result register
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwritten before it was taken");

	// A finished division always leads to the mean request phase
	assert property (@(posedge clk) disable iff (!arst_n)
		div_ack |=> (phase_q == PH_MEAN) && out_valid_q && (action_q == ACT_GET_MEAN))
		else $error("division result not delivered");

endmodule

`default_nettype wire

// File: rtl/core/sensor_calibration_checker_core.sv
// Top level of the sensor calibration checker: configuration registers,
// front end, item queue and back end. Depends on sce_pkg, sce_front,
// sce_queue, sce_back and sce_div.
`default_nettype none

// Host-side calibration controller for an area image sensor. Input items carry
// a command (start, background pixel, calibration mean reply, status reply) and
// a 16-bit value; result items carry the next action, the latest background mean
// and the mean difference. Items that do not fit the current phase are dropped
// without a result. Timing: each item passes through the classifying front
// register and then the queue before the sequencer acts on it; pixels, starts,
// mean replies and status replies are each taken at one per cycle in steady
// state, as long as results are drained. The last pixel of a frame starts the
// iterative divider, which resolves one quotient bit per cycle, so the get-mean
// result appears once the division is done, and no further item is consumed
// meanwhile (the front and queue still accept up to QUEUE_DEPTH + 1 items).
// Configuration writes take effect on the next cycle and are meant to be issued
// only while the block is idle; budget writes take effect at the next start,
// the poll budget also at the next round. No memory clearing pass follows reset.

module sensor_calibration_checker_core
	import sce_pkg::*;
#(
	parameter int QUEUE_DEPTH = SCE_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input item channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] data_value,
	// result item channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       action,
	output logic [15:0]      frame_mean,
	output logic [15:0]      mean_delta
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	// Register file: writes outside the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_count  <= RST_PIXEL_COUNT;
			cfg_q.max_delta    <= RST_MAX_DELTA;
			cfg_q.min_mean     <= RST_MIN_MEAN;
			cfg_q.round_budget <= RST_ROUND_BUDGET;
			cfg_q.poll_budget  <= RST_POLL_BUDGET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_COUNT:  cfg_q.pixel_count  <= cfg_data;
				REG_MAX_DELTA:    cfg_q.max_delta    <= cfg_data;
				REG_MIN_MEAN:     cfg_q.min_mean     <= cfg_data;
				REG_ROUND_BUDGET: cfg_q.round_budget <= cfg_data[7:0];
				REG_POLL_BUDGET:  cfg_q.poll_budget  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Accept and classify items
	sce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.data_value (data_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Decouple the front from the sequencer so either side can stall
	sce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// Carry out the calibration sequence and hold the result register
	sce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.action     (action),
		.frame_mean (frame_mean),
		.mean_delta (mean_delta)
	);

endmodule

`default_nettype wire
